// ----- design/double_ended_priority_queue_macros.svh -----
// Assertion macros for the double-ended priority queue design.
// Depends on nothing; included by the files that carry assertions.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DEPQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DEPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/depq_pkg.sv -----
// Shared types and constants of the double-ended priority queue.
// Depends on nothing; used by depq_cell and double_ended_priority_queue.
package depq_pkg;

    // Default sizes of the queue.
    localparam int CAPACITY_DEF   = 128;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed widths of the request and result fields.
    localparam int MODE_BITS   = 2;
    localparam int FIELD_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 8;

    // Request modes.
    localparam logic [MODE_BITS-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_POP_MAX = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_POP_MIN = 2'd2;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // Update command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop_max;
        logic pop_min;
    } cell_ctrl_t;

    // Flags that a cell hands to its upper neighbor.
    typedef struct packed {
        logic occ;    // cell holds a valid pair
        logic lo_le;  // low entry <= value being inserted
        logic hi_le;  // high entry <= value being inserted
    } cell_link_t;

endpackage

// ----- design/depq_cell.sv -----
// One cell of the folded sorted chain: holds the i-th smallest and i-th largest value.
// Depends on depq_pkg; instantiated by double_ended_priority_queue.
module depq_cell #(
    parameter int VALUE_BITS = depq_pkg::VALUE_BITS_DEF
) (
    input  logic                    aclk,
    input  depq_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0]   ins_value,
    input  logic                    occ,
    input  depq_pkg::cell_link_t    prev_link,
    input  logic [VALUE_BITS-1:0]   prev_lo,
    input  logic [VALUE_BITS-1:0]   prev_hi,
    input  logic                    next_occ,
    input  logic [VALUE_BITS-1:0]   next_lo,
    input  logic [VALUE_BITS-1:0]   next_hi,
    output depq_pkg::cell_link_t    link,
    output logic [VALUE_BITS-1:0]   lo,
    output logic [VALUE_BITS-1:0]   hi
);

    logic [VALUE_BITS-1:0] lo_reg;
    logic [VALUE_BITS-1:0] lo_next;
    logic [VALUE_BITS-1:0] hi_reg;
    logic [VALUE_BITS-1:0] hi_next;
    logic                  lo_le;
    logic                  hi_le;
    logic                  eff_valid;
    logic [VALUE_BITS-1:0] eff_lo;
    logic [VALUE_BITS-1:0] eff_hi;
    logic                  eff_lo_le;
    logic                  eff_hi_le;

    // Compare both held entries against the value being inserted.
    assign lo_le = $signed(lo_reg) <= $signed(ins_value);
    assign hi_le = $signed(hi_reg) <= $signed(ins_value);

    // An empty cell just above the last full one sees that cell's pair crossed over.
    always_comb begin
        eff_valid = occ || prev_link.occ;
        eff_lo    = occ ? lo_reg : prev_hi;
        eff_hi    = occ ? hi_reg : prev_lo;
        eff_lo_le = occ ? lo_le  : prev_link.hi_le;
        eff_hi_le = occ ? hi_le  : prev_link.lo_le;
    end

    // Next pair: shift in from a neighbor, take the new value, move the other entry over, or hold.
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.insert) begin
            if (eff_valid && eff_lo_le) begin
                lo_next = eff_lo;
            end else if (prev_link.lo_le) begin
                lo_next = ins_value;
            end else begin
                lo_next = prev_lo;
            end
            if (prev_link.hi_le) begin
                hi_next = prev_hi;
            end else if (eff_valid && !eff_hi_le) begin
                hi_next = eff_hi;
            end else begin
                hi_next = ins_value;
            end
        end else if (ctrl.pop_max) begin
            hi_next = next_occ ? next_hi : lo_reg;
        end else if (ctrl.pop_min) begin
            lo_next = next_occ ? next_lo : hi_reg;
        end
    end

    // Pair storage; payload only, so no reset.
    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign link = '{occ: occ, lo_le: lo_le, hi_le: hi_le};
    assign lo   = lo_reg;
    assign hi   = hi_reg;

endmodule

// ----- design/double_ended_priority_queue.sv -----
// Double-ended priority queue: holds up to CAPACITY signed values and on each request
// inserts a value or removes the largest or the smallest. It takes one request per clock
// and its result sits in an output register from the next cycle on; s_ready drops only
// while that register is full and m_ready is low. The rate is set by the chain of
// (CAPACITY+1)/2 cells, each holding the i-th smallest and i-th largest value, that all
// update together, so both ends sit in the first cell. Reset empties the queue at
// once; no clearing pass runs. An insert into a full queue and a pop of an empty one
// leave the queue unchanged and are flagged in m_status.
// Depends on depq_pkg, depq_cell and double_ended_priority_queue_macros.svh.
`include "double_ended_priority_queue_macros.svh"

module double_ended_priority_queue #(
    parameter int CAPACITY   = depq_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = depq_pkg::VALUE_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [depq_pkg::MODE_BITS-1:0]          s_mode,
    input  logic signed [depq_pkg::FIELD_BITS-1:0]  s_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [depq_pkg::FIELD_BITS-1:0]  m_popped_value,
    output logic [depq_pkg::STATUS_BITS-1:0]        m_status,
    output logic [depq_pkg::COUNT_BITS-1:0]         m_held_count
);

    localparam int NCELL    = (CAPACITY + 1) / 2;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int XW       = (VALUE_BITS > depq_pkg::FIELD_BITS) ?
                              VALUE_BITS : depq_pkg::FIELD_BITS;
    localparam int CW       = (CNT_BITS > depq_pkg::COUNT_BITS) ?
                              CNT_BITS : depq_pkg::COUNT_BITS;

    logic                                   accept;
    logic [CNT_BITS-1:0]                    count_reg;
    logic [CNT_BITS-1:0]                    count_next;
    logic                                   m_valid_reg;
    logic                                   m_valid_next;
    logic [depq_pkg::FIELD_BITS-1:0]        popped_reg;
    logic [depq_pkg::FIELD_BITS-1:0]        popped_next;
    logic [depq_pkg::STATUS_BITS-1:0]       status_reg;
    logic [depq_pkg::STATUS_BITS-1:0]       status_next;
    logic [depq_pkg::COUNT_BITS-1:0]        held_reg;
    logic [depq_pkg::COUNT_BITS-1:0]        held_next;
    logic                                   is_full;
    logic                                   is_empty;
    depq_pkg::cell_ctrl_t                   ctrl;
    logic [XW-1:0]                          ins_wide;
    logic [VALUE_BITS-1:0]                  ins_value;
    logic [XW-1:0]                          top_hi_wide;
    logic [XW-1:0]                          top_lo_wide;
    logic [CW-1:0]                          count_wide;
    logic                                   occ       [NCELL+1];
    depq_pkg::cell_link_t                   link      [NCELL+1];
    logic [VALUE_BITS-1:0]                  cell_lo   [NCELL+1];
    logic [VALUE_BITS-1:0]                  cell_hi   [NCELL+1];

    // Handshake: a new request is taken whenever the result register frees up.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Width adaption between the fixed fields and the stored value width.
    assign ins_wide    = XW'($unsigned(s_value));
    assign ins_value   = ins_wide[VALUE_BITS-1:0];
    assign top_hi_wide = XW'(cell_hi[1]);
    assign top_lo_wide = XW'(cell_lo[1]);
    assign count_wide  = CW'(count_next);

    assign is_full  = count_reg == CNT_BITS'(CAPACITY);
    assign is_empty = count_reg == '0;

    // Decode the request into a chain command, a result and the new count.
    always_comb begin
        ctrl        = '0;
        count_next  = count_reg;
        popped_next = '0;
        status_next = depq_pkg::ST_OK;
        case (s_mode)
            depq_pkg::MODE_INSERT: begin
                if (is_full) begin
                    status_next = depq_pkg::ST_FULL;
                end else begin
                    ctrl.insert = accept;
                    count_next  = count_reg + 1'b1;
                end
            end
            depq_pkg::MODE_POP_MAX: begin
                if (is_empty) begin
                    status_next = depq_pkg::ST_EMPTY;
                end else begin
                    ctrl.pop_max = accept;
                    popped_next  = top_hi_wide[depq_pkg::FIELD_BITS-1:0];
                    count_next   = count_reg - 1'b1;
                end
            end
            depq_pkg::MODE_POP_MIN: begin
                if (is_empty) begin
                    status_next = depq_pkg::ST_EMPTY;
                end else begin
                    ctrl.pop_min = accept;
                    popped_next  = top_lo_wide[depq_pkg::FIELD_BITS-1:0];
                    count_next   = count_reg - 1'b1;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        held_next = count_wide[depq_pkg::COUNT_BITS-1:0];
    end

    // Result register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state with reset, result payload without.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            popped_reg <= popped_next;
            status_reg <= status_next;
            held_reg   <= held_next;
        end
    end

    // Boundary ties: below the first cell and above the last one.
    assign link[0]    = '{occ: 1'b0, lo_le: 1'b1, hi_le: 1'b0};
    assign cell_lo[0] = '0;
    assign cell_hi[0] = '0;
    assign occ[NCELL] = 1'b0;

    // The chain of cells; entry i+1 of the link, lo and hi arrays belongs to cell i.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        assign occ[i] = (CNT_BITS + 1)'(2 * i) < {1'b0, count_reg};

        depq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .ins_value (ins_value),
            .occ       (occ[i]),
            .prev_link (link[i]),
            .prev_lo   (cell_lo[i]),
            .prev_hi   (cell_hi[i]),
            .next_occ  (occ[i+1]),
            .next_lo   (cell_lo[i+2 > NCELL ? NCELL : i+2]),
            .next_hi   (cell_hi[i+2 > NCELL ? NCELL : i+2]),
            .link      (link[i+1]),
            .lo        (cell_lo[i+1]),
            .hi        (cell_hi[i+1])
        );
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = popped_reg;
    assign m_status       = status_reg;
    assign m_held_count   = held_reg;

    // The count never goes past the capacity.
    `DEPQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_BITS'(CAPACITY), "count beyond capacity")
    // A refused insert leaves the count alone and reports full.
    `DEPQ_ASSERT_NEXT(a_full_refuse, aclk, aresetn, accept && s_mode == depq_pkg::MODE_INSERT && is_full, m_status == depq_pkg::ST_FULL && count_reg == $past(count_reg), "full insert not refused")
    // A pop on an empty queue reports empty with a zero value.
    `DEPQ_ASSERT_NEXT(a_empty_pop, aclk, aresetn, accept && is_empty && (s_mode == depq_pkg::MODE_POP_MAX || s_mode == depq_pkg::MODE_POP_MIN), m_status == depq_pkg::ST_EMPTY && m_popped_value == '0 && count_reg == '0, "empty pop misreported")
    // When occupied, the first cell holds a smallest value no greater than its largest.
    `DEPQ_ASSERT_SAME(a_ends_order, aclk, aresetn, occ[0], $signed(cell_lo[1]) <= $signed(cell_hi[1]), "queue ends out of order")

endmodule
